FILE: src/bpc_pkg.sv
// Shared types and constants for the button press classifier.
// No dependencies; compiled first.
`default_nettype none

package bpc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned MsW    = 16;
  localparam int unsigned EventW = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic           ActiveLevelRst = 1'b1;
  localparam logic [MsW-1:0] DebounceRst    = 16'd30;
  localparam logic [MsW-1:0] LongPressRst   = 16'd500;
  localparam logic [MsW-1:0] RepeatRst      = 16'd200;

  typedef enum logic [EventW-1:0] {
    EV_NONE      = 3'd0,
    EV_PRESSED   = 3'd1,
    EV_LONG      = 3'd2,
    EV_REPEAT    = 3'd3,
    EV_SHORT_REL = 3'd4,
    EV_LONG_REL  = 3'd5
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACTIVE_LEVEL = 2'd0,
    CFG_DEBOUNCE     = 2'd1,
    CFG_LONG_PRESS   = 2'd2,
    CFG_REPEAT       = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic           active_level;
    logic [MsW-1:0] debounce_ms;
    logic [MsW-1:0] long_press_ms;
    logic [MsW-1:0] repeat_ms;
  } cfg_t;

  typedef struct packed {
    logic             pin_level;
    logic [TimeW-1:0] now_ms;
  } sample_t;

  // Press tracking flags, exported for checking.
  typedef struct packed {
    logic held;
    logic long_press;
  } status_t;

endpackage

`default_nettype wire

FILE: src/bpc_if.sv
// Handshake channel interfaces for samples in and events out.
// Depends on bpc_pkg.
`default_nettype none

interface bpc_in_if;
  logic                      valid;
  logic                      ready;
  logic                      pin_level;
  logic [bpc_pkg::TimeW-1:0] now_ms;

  modport source (output valid, output pin_level, output now_ms, input ready);
  modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface bpc_out_if;
  logic                       valid;
  logic                       ready;
  logic [bpc_pkg::EventW-1:0] event_code;

  modport source (output valid, output event_code, input ready);
  modport sink   (input valid, input event_code, output ready);
endinterface

`default_nettype wire

FILE: src/bpc_cfg.sv
// Configuration register file: active level and the three time thresholds.
// Depends on bpc_pkg.
`default_nettype none

module bpc_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [bpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bpc_pkg::CfgDataW-1:0] cfg_data_i,
  output bpc_pkg::cfg_t                     cfg_o
);
  import bpc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ACTIVE_LEVEL: cfg_d.active_level  = cfg_data_i[0];
        CFG_DEBOUNCE:     cfg_d.debounce_ms   = cfg_data_i[MsW-1:0];
        CFG_LONG_PRESS:   cfg_d.long_press_ms = cfg_data_i[MsW-1:0];
        CFG_REPEAT:       cfg_d.repeat_ms     = cfg_data_i[MsW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_level  <= ActiveLevelRst;
      cfg_q.debounce_ms   <= DebounceRst;
      cfg_q.long_press_ms <= LongPressRst;
      cfg_q.repeat_ms     <= RepeatRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: src/bpc_core.sv
// Press state and single-pass classification of one sample per step.
// Depends on bpc_pkg.
`default_nettype none

module bpc_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire bpc_pkg::sample_t sample_i,
  input  wire bpc_pkg::cfg_t    cfg_i,
  output bpc_pkg::event_e       event_o,
  output bpc_pkg::status_t      status_o
);
  import bpc_pkg::*;

  logic             held_q, held_d;
  logic             long_q, long_d;
  logic [TimeW-1:0] press_start_q, press_start_d;
  logic [TimeW-1:0] last_repeat_q, last_repeat_d;

  logic             pressed;
  logic [TimeW-1:0] start_eff;
  logic [TimeW-1:0] dt_press;
  logic [TimeW-1:0] dt_repeat;
  logic             repeat_hit;
  logic             long_hit;
  logic             debounce_ok;

  assign pressed   = (sample_i.pin_level == cfg_i.active_level);
  // a fresh press measures from this very sample
  assign start_eff = held_q ? press_start_q : sample_i.now_ms;
  assign dt_press  = sample_i.now_ms - start_eff;
  assign dt_repeat = sample_i.now_ms - last_repeat_q;

  assign repeat_hit  = long_q && (dt_repeat > {{(TimeW-MsW){1'b0}}, cfg_i.repeat_ms});
  assign long_hit    = !long_q && (dt_press > {{(TimeW-MsW){1'b0}}, cfg_i.long_press_ms});
  assign debounce_ok = dt_press > {{(TimeW-MsW){1'b0}}, cfg_i.debounce_ms};

  always_comb begin
    held_d        = held_q;
    long_d        = long_q;
    press_start_d = press_start_q;
    last_repeat_d = last_repeat_q;
    event_o       = EV_NONE;
    if (pressed) begin
      held_d        = 1'b1;
      press_start_d = start_eff;
      if (!held_q) begin
        event_o = EV_PRESSED;
      end
      // repeat and long checks are exclusive through long_q
      if (repeat_hit) begin
        event_o       = EV_REPEAT;
        last_repeat_d = sample_i.now_ms;
      end
      if (long_hit) begin
        event_o = EV_LONG;
        long_d  = 1'b1;
      end
    end else if (held_q) begin
      held_d = 1'b0;
      if (long_q) begin
        long_d        = 1'b0;
        last_repeat_d = '0;
        event_o       = EV_LONG_REL;
      end else if (debounce_ok) begin
        event_o = EV_SHORT_REL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q        <= 1'b0;
      long_q        <= 1'b0;
      press_start_q <= '0;
      last_repeat_q <= '0;
    end else if (step_i) begin
      held_q        <= held_d;
      long_q        <= long_d;
      press_start_q <= press_start_d;
      last_repeat_q <= last_repeat_d;
    end
  end

  assign status_o = '{held: held_q, long_press: long_q};

endmodule

`default_nettype wire

FILE: src/button_press_classifier_unit.sv
// Button press classifier: each item is one pin sample with a millisecond
// timestamp and yields exactly one event code (none, pressed, long pressed,
// repeating, short release, long release). Samples are taken one per cycle
// sustained while the output is not stalled; a sample lands in the input
// register when accepted and its result is loaded into the result register,
// from which it is taken. The combinational update of the press state
// between the two registers sets that rate. A stalled output holds the
// pipeline. Configuration writes are meant for idle periods only.
// Depends on bpc_pkg, bpc_if, bpc_cfg and bpc_core.
`default_nettype none

module button_press_classifier_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  bpc_in_if.sink                            in_i,
  bpc_out_if.source                         out_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [bpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bpc_pkg::CfgDataW-1:0] cfg_data_i
);
  import bpc_pkg::*;

  cfg_t    cfg;
  status_t status;
  event_e  core_event;

  logic    s1_valid_q, s1_valid_d;
  sample_t s1_sample_q;
  logic    out_valid_q, out_valid_d;
  event_e  out_event_q;

  logic    advance;
  logic    in_ready;
  logic    in_accept;
  logic    step;

  // result register is free or being emptied this cycle
  assign advance   = !out_valid_q || out_o.ready;
  assign in_ready  = !s1_valid_q || advance;
  assign in_accept = in_i.valid && in_ready;
  assign step      = s1_valid_q && advance;

  bpc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  bpc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .sample_i (s1_sample_q),
    .cfg_i    (cfg),
    .event_o  (core_event),
    .status_o (status)
  );

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (in_ready) begin
      s1_valid_d = in_i.valid;
    end
    if (advance) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_sample_q.pin_level <= in_i.pin_level;
      s1_sample_q.now_ms    <= in_i.now_ms;
    end
    if (step) begin
      out_event_q <= core_event;
    end
  end

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.event_code = out_event_q;

  // a long press only exists inside a held press
  a_long_within_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.long_press |-> status.held)
    else $error("long-press flag set without a held press");

  // an accepted item always lands in the input register
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted item lost before the input register");

  // reporting a long press must leave the long flag set
  a_long_event_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && (core_event == EV_LONG)) |=> status.long_press)
    else $error("long-press event without long flag");

  // a step always produces a valid result in the next cycle
  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> (out_valid_q && (out_event_q <= EV_LONG_REL)))
    else $error("step did not yield a valid event");

endmodule

`default_nettype wire

FILE: verif/bpc_checker.sv
// Scoreboard for the button press classifier: watches both channels and the
// register port, predicts each event code and compares in order.
// Depends on bpc_pkg.
`timescale 1ns / 100ps

module bpc_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic                         in_pin_level_i,
  input  logic [bpc_pkg::TimeW-1:0]    in_now_ms_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [bpc_pkg::EventW-1:0]   out_event_code_i,
  input  logic                         cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bpc_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           error_count_o,
  output int                           pending_o,
  output int                           checked_o
);
  import bpc_pkg::*;

  cfg_t             cfg_q;
  logic             held_q;
  logic             long_q;
  logic [TimeW-1:0] press_start_q;
  logic [TimeW-1:0] last_repeat_q;

  event_e expected_events[$];
  event_e head_event;
  int     mismatches;
  int     events_checked;

  // Checks run press, repeat, long; a later hit overrides the code.
  function automatic event_e classify_sample(input logic pin, input logic [TimeW-1:0] stamp);
    event_e           ev;
    logic [TimeW-1:0] since_repeat;
    logic [TimeW-1:0] since_press;
    ev = EV_NONE;
    if (pin == cfg_q.active_level) begin
      if (!held_q) begin
        held_q        = 1'b1;
        ev            = EV_PRESSED;
        press_start_q = stamp;
      end
      since_repeat = stamp - last_repeat_q;
      if (long_q && since_repeat > {16'd0, cfg_q.repeat_ms}) begin
        ev            = EV_REPEAT;
        last_repeat_q = stamp;
      end
      since_press = stamp - press_start_q;
      if (!long_q && since_press > {16'd0, cfg_q.long_press_ms}) begin
        long_q = 1'b1;
        ev     = EV_LONG;
      end
    end else if (held_q) begin
      since_press = stamp - press_start_q;
      if (long_q) begin
        long_q        = 1'b0;
        last_repeat_q = '0;
        ev            = EV_LONG_REL;
      end else if (since_press > {16'd0, cfg_q.debounce_ms}) begin
        ev = EV_SHORT_REL;
      end
      held_q = 1'b0;
    end
    return ev;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q          = '{ActiveLevelRst, DebounceRst, LongPressRst, RepeatRst};
      held_q         = 1'b0;
      long_q         = 1'b0;
      press_start_q  = '0;
      last_repeat_q  = '0;
      mismatches     = 0;
      events_checked = 0;
      expected_events.delete();
      error_count_o <= 0;
      pending_o     <= 0;
      checked_o     <= 0;
    end else begin
      // A result at this edge belongs to an item taken at an earlier edge.
      if (out_valid_i && out_ready_i) begin
        if (expected_events.size() == 0) begin
          $error("event_code: expected none outstanding, actual %0d", out_event_code_i);
          mismatches++;
        end else begin
          head_event = expected_events.pop_front();
          if (out_event_code_i !== head_event) begin
            $error("event_code: expected %0d (%s), actual %0d",
                   head_event, head_event.name(), out_event_code_i);
            mismatches++;
          end
          events_checked++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_events.push_back(classify_sample(in_pin_level_i, in_now_ms_i));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACTIVE_LEVEL: cfg_q.active_level  = cfg_data_i[0];
          CFG_DEBOUNCE:     cfg_q.debounce_ms   = cfg_data_i;
          CFG_LONG_PRESS:   cfg_q.long_press_ms = cfg_data_i;
          CFG_REPEAT:       cfg_q.repeat_ms     = cfg_data_i;
          default: ;
        endcase
      end
      error_count_o <= mismatches;
      pending_o     <= expected_events.size();
      checked_o     <= events_checked;
    end
  end

endmodule

FILE: verif/tb_button_press_classifier_unit.sv
// Top of the button press classifier testbench: clock, reset, sample stimulus,
// register settings, output back-pressure and the verdict.
// Depends on bpc_pkg, bpc_if, the block and bpc_checker.
`timescale 1ns / 100ps

module tb_button_press_classifier_unit;
  import bpc_pkg::*;

  localparam int RandomItems = 1950;
  localparam int NumPhases   = 6;
  localparam int DrainCycles = 6;
  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 150;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  bpc_in_if  in_ch ();
  bpc_out_if out_ch ();

  int error_count;
  int pending;
  int checked;

  int               cycle_count;
  int               items_sent;
  int               send_idle_pct;
  int               recv_idle_pct;
  logic             cur_al;
  int               cur_db;
  int               cur_lp;
  int               cur_rp;
  logic [TimeW-1:0] t_now;

  button_press_classifier_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  bpc_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_ch.valid),
    .in_ready_i       (in_ch.ready),
    .in_pin_level_i   (in_ch.pin_level),
    .in_now_ms_i      (in_ch.now_ms),
    .out_valid_i      (out_ch.valid),
    .out_ready_i      (out_ch.ready),
    .out_event_code_i (out_ch.event_code),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .error_count_o    (error_count),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d events outstanding", cycle_count, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off now and then so the
  // pipeline fills and the input side stalls too.
  initial begin
    int hold_left;
    int seen;
    int next_hold_at;
    out_ch.ready = 1'b0;
    hold_left    = 0;
    seen         = 0;
    next_hold_at = 200;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) seen++;
      if (hold_left == 0 && seen >= next_hold_at) begin
        hold_left    = HoldCycles;
        next_hold_at = next_hold_at + 1280;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_sample(input logic pin, input logic [TimeW-1:0] stamp);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.pin_level <= pin;
    in_ch.now_ms    <= stamp;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic al, input logic [MsW-1:0] db,
                                input logic [MsW-1:0] lp, input logic [MsW-1:0] rp);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_ACTIVE_LEVEL;
    cfg_data <= {15'd0, al};
    @(posedge clk_i);
    cfg_idx  <= CFG_DEBOUNCE;
    cfg_data <= db;
    @(posedge clk_i);
    cfg_idx  <= CFG_LONG_PRESS;
    cfg_data <= lp;
    @(posedge clk_i);
    cfg_idx  <= CFG_REPEAT;
    cfg_data <= rp;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cur_al = al;
    cur_db = db;
    cur_lp = lp;
    cur_rp = rp;
  endtask

  // Time steps scaled to the current thresholds so boundaries get hit.
  function automatic logic [TimeW-1:0] next_step();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 3);
      6, 7, 8, 9:       return $urandom_range(0, cur_rp + 2);
      10, 11, 12, 13:   return $urandom_range(0, cur_lp + 2);
      14, 15, 16, 17:   return $urandom_range(0, cur_db + 2);
      default:          return $urandom();
    endcase
  endfunction

  task automatic press_episode();
    int holds;
    if ($urandom_range(0, 7) == 0) t_now = $urandom();
    repeat ($urandom_range(0, 2)) begin
      t_now = t_now + next_step();
      send_sample(!cur_al, t_now);
    end
    t_now = t_now + next_step();
    send_sample(cur_al, t_now);
    holds = $urandom_range(0, 8);
    repeat (holds) begin
      t_now = t_now + next_step();
      send_sample(cur_al, t_now);
    end
    // now and then the release is left out and the next episode runs on
    if ($urandom_range(0, 7) != 0) begin
      t_now = t_now + next_step();
      send_sample(!cur_al, t_now);
    end
  endtask

  task automatic random_burst();
    if ($urandom_range(0, 9) < 8) begin
      press_episode();
    end else begin
      repeat ($urandom_range(1, 4)) send_sample(1'($urandom_range(0, 1)), $urandom());
    end
  endtask

  initial begin
    int phase_end;
    in_ch.valid     = 1'b0;
    in_ch.pin_level = 1'b0;
    in_ch.now_ms    = '0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_ACTIVE_LEVEL;
    cfg_data        = '0;
    rst_ni          = 1'b0;
    items_sent      = 0;
    send_idle_pct   = 27;
    recv_idle_pct   = 52;
    cur_al          = ActiveLevelRst;
    cur_db          = DebounceRst;
    cur_lp          = LongPressRst;
    cur_rp          = RepeatRst;
    t_now           = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset settings: active high, 30 / 500 / 200 ms.
    send_sample(1'b0, 32'd0);            // idle release
    send_sample(1'b1, 32'd100);          // pressed
    send_sample(1'b1, 32'd130);
    send_sample(1'b0, 32'd130);          // release within debounce: none
    send_sample(1'b1, 32'd1000);
    send_sample(1'b0, 32'd1031);         // short release
    send_sample(1'b1, 32'd2000);
    send_sample(1'b1, 32'd2500);         // exactly long_press_ms: not yet
    send_sample(1'b1, 32'd2501);         // long
    send_sample(1'b1, 32'd2502);         // first repeat straight away
    send_sample(1'b1, 32'd2702);         // exactly repeat_ms: none
    send_sample(1'b1, 32'd2703);         // repeat
    send_sample(1'b0, 32'd2800);         // long release
    send_sample(1'b1, 32'hFFFF_FF00);    // press across the wrap
    send_sample(1'b1, 32'h0000_0100);    // long after wrap
    send_sample(1'b1, 32'h0000_0101);    // repeat, last repeat back at zero
    send_sample(1'b0, 32'h0000_0200);
    send_sample(1'b1, 32'hFFFF_FFFF);
    send_sample(1'b0, 32'hFFFF_FFFF);    // zero-length press
    send_sample(1'b0, 32'hFFFF_FFFF);
    send_sample(1'b1, 32'h0000_0000);
    send_sample(1'b0, 32'h8000_0000);
    t_now = 32'h8000_0000;

    for (int phase = 0; phase < NumPhases; phase++) begin
      wait_drained();
      case (phase)
        0: apply_settings(1'b1, 16'd30, 16'd500, 16'd200);
        1: apply_settings(1'b0, 16'd0, 16'd0, 16'd0);
        2: apply_settings(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: apply_settings(1'b0, 16'($urandom_range(0, 100)), 16'($urandom_range(0, 400)),
                          16'($urandom_range(0, 150)));
        4: apply_settings(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        default: apply_settings(1'b1, 16'($urandom_range(0, 40)),
                                16'($urandom_range(0, 1000)), 16'($urandom_range(0, 300)));
      endcase
      if (phase < 2) begin
        send_idle_pct = 27;
        recv_idle_pct = 52;
      end else if (phase < 4) begin
        send_idle_pct = 52;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      phase_end = items_sent + RandomItems / NumPhases;
      while (items_sent < phase_end) random_burst();
    end

    wait_drained();
    $display("Sent %0d samples under %0d register settings; %0d events compared, %0d mismatches",
             items_sent, NumPhases + 1, checked, error_count);
    if (error_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
